// ===== hdl/asgr_pkg.sv =====
// Shared types, constants and the colour remap function of the ANSI SGR escape parser.
`default_nettype none
package asgr_pkg;

   // Parser states; the unused code behaves as ground.
   typedef enum logic [1:0] {
      ST_GROUND = 2'd0,
      ST_ESCAPE = 2'd1,
      ST_PARAM  = 2'd2
   } parse_state_type;

   // Configuration register indexes.
   localparam logic [1:0] CSR_RED    = 2'd0;
   localparam logic [1:0] CSR_YELLOW = 2'd1;
   localparam logic [1:0] CSR_BLUE   = 2'd2;
   localparam logic [1:0] CSR_CYAN   = 2'd3;

   // Result kinds.
   localparam logic KIND_CHAR   = 1'b0;
   localparam logic KIND_COLOUR = 1'b1;

   // Bytes and numbers of interest.
   localparam logic [7:0] BYTE_ESC    = 8'h1B;
   localparam logic [7:0] BYTE_LBRACK = 8'h5B;
   localparam logic [7:0] BYTE_SEMI   = 8'h3B;
   localparam logic [7:0] BYTE_M      = 8'h6D;
   localparam logic [7:0] BYTE_ZERO   = 8'h30;
   localparam logic [7:0] PARAM_BRIGHT = 8'd1;
   localparam logic [7:0] PARAM_FG_LO  = 8'd30;
   localparam logic [7:0] PARAM_BG_LO  = 8'd40;
   localparam logic [3:0] DEF_FG      = 4'h7;
   localparam logic [3:0] DEF_BG      = 4'h0;
   localparam logic [2:0] DEF_FG_CODE = 3'd7;
   localparam logic [2:0] DEF_BG_CODE = 3'd0;
   localparam logic [3:0] BRIGHT_BIT  = 4'h8;
   localparam logic [7:0] ACC_MAX     = 8'd255;

   // Colour remap table written through the configuration port.
   typedef struct packed {
      logic [3:0] red;
      logic [3:0] yellow;
      logic [3:0] blue;
      logic [3:0] cyan;
   } colour_map_type;

   // One result beat.
   typedef struct packed {
      logic       kind;
      logic [7:0] character;
      logic [3:0] foreground;
      logic [3:0] background;
   } result_type;

   // Maps an ANSI colour code to a display colour index.
   function automatic logic [3:0] remap(input logic [2:0] code, input colour_map_type cmap);
      logic [3:0] colour;
      case (code)
         3'd1: colour = cmap.red;
         3'd3: colour = cmap.yellow;
         3'd4: colour = cmap.blue;
         3'd6: colour = cmap.cyan;
         default: colour = {1'b0, code};
      endcase
      return colour;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/asgr_csr.sv =====
// Configuration registers holding the colour remap table.
`default_nettype none
module asgr_csr (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_wen,
   input  wire logic [1:0]              csr_addr,
   input  wire logic [3:0]              csr_wdata,
   output asgr_pkg::colour_map_type     cmap
);
   import asgr_pkg::*;

   colour_map_type cmap_ff, cmap_in;

   // Decode the write into the addressed register.
   always_comb begin
      cmap_in = cmap_ff;
      if (csr_wen) begin
         case (csr_addr)
            CSR_RED:    cmap_in.red    = csr_wdata;
            CSR_YELLOW: cmap_in.yellow = csr_wdata;
            CSR_BLUE:   cmap_in.blue   = csr_wdata;
            CSR_CYAN:   cmap_in.cyan   = csr_wdata;
            default:    cmap_in = cmap_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmap_ff <= '{red: 4'd4, yellow: 4'd6, blue: 4'd1, cyan: 4'd3};
      end else begin
         cmap_ff <= cmap_in;
      end
   end

   assign cmap = cmap_ff;

endmodule
`default_nettype wire

// ===== hdl/asgr_parser.sv =====
// Input register, parser state and the single-pass step logic.
`default_nettype none
module asgr_parser (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire logic [7:0]              req_tdata,
   input  wire asgr_pkg::colour_map_type cmap,
   input  wire logic                    res_ready,
   output logic                         res_valid,
   output asgr_pkg::result_type         res
);
   import asgr_pkg::*;

   logic            in_valid_ff, in_valid_in;
   logic [7:0]      in_byte_ff;
   logic            advance;

   parse_state_type state_ff, state_in;
   logic [7:0]      acc_ff, acc_in;
   logic            fdone_ff, fdone_in;
   logic            fzero_ff, fzero_in;
   logic            bright_ff, bright_in;
   logic [2:0]      pfg_ff, pfg_in;
   logic [2:0]      pbg_ff, pbg_in;
   logic [3:0]      cur_fg_ff, cur_fg_in;
   logic [3:0]      cur_bg_ff, cur_bg_in;

   logic [11:0]     acc_next;
   logic [7:0]      fg_diff, bg_diff;
   logic            f_done, f_zero, f_bright;
   logic [2:0]      f_pfg, f_pbg;
   logic [3:0]      f_fg, f_bg;
   logic            has_res;

   // The input register moves on whenever the result side can take a beat.
   assign advance     = in_valid_ff && res_ready;
   assign req_tready  = !in_valid_ff || advance;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
   end

   // Decimal fold of one digit: acc * 10 + digit, saturated later.
   assign acc_next = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0}
                     + {4'b0000, in_byte_ff - BYTE_ZERO};
   assign fg_diff  = acc_ff - PARAM_FG_LO;
   assign bg_diff  = acc_ff - PARAM_BG_LO;

   // Parameter completion: fold the collected value into the flags and form the colours.
   always_comb begin
      f_done   = fdone_ff;
      f_zero   = fzero_ff;
      f_bright = bright_ff;
      f_pfg    = pfg_ff;
      f_pbg    = pbg_ff;
      if (!fdone_ff) begin
         f_done = 1'b1;
         f_zero = (acc_ff == 8'd0);
      end
      if (acc_ff == PARAM_BRIGHT) begin
         f_bright = 1'b1;
      end
      if (acc_ff inside {[8'd30:8'd37]}) begin
         f_pfg = fg_diff[2:0];
      end
      if (acc_ff inside {[8'd40:8'd47]}) begin
         f_pbg = bg_diff[2:0];
      end
      if (f_zero) begin
         f_fg = DEF_FG;
         f_bg = DEF_BG;
      end else begin
         f_fg = remap(f_pfg, cmap);
         f_bg = remap(f_pbg, cmap);
         if (f_bright) begin
            f_fg = f_fg | BRIGHT_BIT;
            f_bg = f_bg | BRIGHT_BIT;
         end
      end
   end

   // Next state and result for the byte in the input register.
   always_comb begin
      state_in  = state_ff;
      acc_in    = acc_ff;
      fdone_in  = fdone_ff;
      fzero_in  = fzero_ff;
      bright_in = bright_ff;
      pfg_in    = pfg_ff;
      pbg_in    = pbg_ff;
      cur_fg_in = cur_fg_ff;
      cur_bg_in = cur_bg_ff;
      has_res   = 1'b0;
      res       = '{kind: KIND_CHAR, character: in_byte_ff,
                    foreground: cur_fg_ff, background: cur_bg_ff};
      case (state_ff)
         ST_ESCAPE: begin
            if (in_byte_ff == BYTE_LBRACK) begin
               state_in  = ST_PARAM;
               acc_in    = 8'd0;
               fdone_in  = 1'b0;
               fzero_in  = 1'b0;
               bright_in = 1'b0;
               pfg_in    = DEF_FG_CODE;
               pbg_in    = DEF_BG_CODE;
            end else begin
               state_in = ST_GROUND;
            end
         end
         ST_PARAM: begin
            if (in_byte_ff inside {[8'h30:8'h39]}) begin
               acc_in = (acc_next > {4'b0000, ACC_MAX}) ? ACC_MAX : acc_next[7:0];
            end else begin
               acc_in    = 8'd0;
               fdone_in  = f_done;
               fzero_in  = f_zero;
               bright_in = f_bright;
               pfg_in    = f_pfg;
               pbg_in    = f_pbg;
               if (in_byte_ff != BYTE_SEMI) begin
                  state_in = ST_GROUND;
                  if (in_byte_ff == BYTE_M) begin
                     cur_fg_in = f_fg;
                     cur_bg_in = f_bg;
                     has_res   = 1'b1;
                     res       = '{kind: KIND_COLOUR, character: 8'd0,
                                   foreground: f_fg, background: f_bg};
                  end
               end
            end
         end
         default: begin
            // Ground, and the unused code that behaves as ground.
            if (in_byte_ff == BYTE_ESC) begin
               state_in = ST_ESCAPE;
            end else begin
               state_in = ST_GROUND;
               has_res  = 1'b1;
            end
         end
      endcase
   end

   assign res_valid = advance && has_res;

   // Parser state registers update once per consumed beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_GROUND;
         acc_ff    <= 8'd0;
         fdone_ff  <= 1'b0;
         fzero_ff  <= 1'b0;
         bright_ff <= 1'b0;
         pfg_ff    <= DEF_FG_CODE;
         pbg_ff    <= DEF_BG_CODE;
         cur_fg_ff <= DEF_FG;
         cur_bg_ff <= DEF_BG;
      end else if (advance) begin
         state_ff  <= state_in;
         acc_ff    <= acc_in;
         fdone_ff  <= fdone_in;
         fzero_ff  <= fzero_in;
         bright_ff <= bright_in;
         pfg_ff    <= pfg_in;
         pbg_ff    <= pbg_in;
         cur_fg_ff <= cur_fg_in;
         cur_bg_ff <= cur_bg_in;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/asgr_out_reg.sv =====
// Result register driving the master-side stream.
`default_nettype none
module asgr_out_reg (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              res_valid,
   input  wire asgr_pkg::result_type res,
   output logic                   res_ready,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [15:0]            rsp_tdata,
   output logic                   rsp_tuser
);
   import asgr_pkg::*;

   logic       out_valid_ff, out_valid_in;
   result_type out_ff;

   // A new beat may be loaded when the register is empty or being drained.
   assign res_ready    = !out_valid_ff || rsp_tready;
   assign out_valid_in = res_valid || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         out_ff <= res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_ff.background, out_ff.foreground, out_ff.character};
   assign rsp_tuser  = out_ff.kind;

endmodule
`default_nettype wire

// ===== hdl/ansi_sgr_escape_parser_top.sv =====
// Top level of the ANSI SGR colour escape parser.
`default_nettype none
// Takes one terminal byte per beat and sustains one beat per cycle unless the
// result side stalls: each byte passes an input register, a single combinational
// step of the parser state machine, and the result register; a printable byte
// or a colour update is offered on the result side after both registers, later
// only while back-pressure holds the result register full. ESC opens an escape,
// ESC '[' opens a control sequence with ';'-separated decimal parameters
// (saturating at 255), and a final 'm' applies the colour rules; escapes and
// sequences otherwise produce no beat. The remap table for ANSI colours 1, 3, 4
// and 6 is written through the csr port, and should only be written while the
// parser is idle.
module ansi_sgr_escape_parser_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] byte_in
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [7:0] character, [11:8] foreground,
                                         // [15:12] background
   output logic             rsp_tuser,   // [0] result_kind
   input  wire logic        csr_wen,
   input  wire logic [1:0]  csr_addr,
   input  wire logic [3:0]  csr_wdata
);
   import asgr_pkg::*;

   colour_map_type cmap;
   result_type     res;
   logic           res_valid;
   logic           res_ready;

   // Colour remap registers.
   asgr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cmap      (cmap)
   );

   // Parser step.
   asgr_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .cmap       (cmap),
      .res_ready  (res_ready),
      .res_valid  (res_valid),
      .res        (res)
   );

   // Result register.
   asgr_out_reg u_out (
      .clock      (clock),
      .reset      (reset),
      .res_valid  (res_valid),
      .res        (res),
      .res_ready  (res_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking stream testbench for the ANSI SGR colour escape parser.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import asgr_pkg::*;

   // Ports of the block; every input starts at a known value.
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_wen    = 1'b0;
   logic [1:0]  csr_addr   = CSR_RED;
   logic [3:0]  csr_wdata  = 4'h0;

   ansi_sgr_escape_parser_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // Clock with a 12 ns period.
   always #6 clock = ~clock;

   // Stimulus bytes waiting for the driver, and the screen beats still to come.
   logic [7:0]  byte_queue[$];
   result_type  pending_screen[$];
   int unsigned bytes_queued   = 0;
   int unsigned bytes_accepted = 0;
   int unsigned fault_count    = 0;
   bit          req_taken      = 1'b0;

   // Idling controls; the percentages and long-hold requests are set per phase by the sequencer.
   int unsigned req_idle_pct = 0;
   int unsigned rsp_idle_pct = 0;
   int unsigned req_gap_left = 0;
   int unsigned hold_left    = 0;
   int unsigned long_holds_asked  = 0;
   int unsigned long_holds_served = 0;

   // Shadow of the parser state and the colour table.
   parse_state_type prs_state    = ST_GROUND;
   logic [7:0]      prm_acc      = 8'd0;
   logic            first_done   = 1'b0;
   logic            first_zero   = 1'b0;
   logic            bright_on    = 1'b0;
   logic [2:0]      fg_code_pend = DEF_FG_CODE;
   logic [2:0]      bg_code_pend = DEF_BG_CODE;
   logic [3:0]      fg_now       = DEF_FG;
   logic [3:0]      bg_now       = DEF_BG;
   colour_map_type  colour_map   = '{red: 4'd4, yellow: 4'd6, blue: 4'd1, cyan: 4'd3};

   // Gap lengths: mostly short, now and then long.
   function automatic int unsigned gap_len();
      if ($urandom_range(0, 9) == 0)
         return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   // Translates an ANSI colour code into a display colour index.
   function automatic logic [3:0] display_colour(input logic [2:0] code);
      case (code)
         3'd1: return colour_map.red;
         3'd3: return colour_map.yellow;
         3'd4: return colour_map.blue;
         3'd6: return colour_map.cyan;
         default: return {1'b0, code};
      endcase
   endfunction

   // Folds the completed parameter into the pending attributes.
   function automatic void fold_parameter();
      logic [7:0] offs;
      if (!first_done) begin
         first_done = 1'b1;
         first_zero = (prm_acc == 8'd0);
      end
      if (prm_acc == PARAM_BRIGHT)
         bright_on = 1'b1;
      if (prm_acc >= PARAM_FG_LO && prm_acc <= PARAM_FG_LO + 8'd7) begin
         offs = prm_acc - PARAM_FG_LO;
         fg_code_pend = offs[2:0];
      end
      if (prm_acc >= PARAM_BG_LO && prm_acc <= PARAM_BG_LO + 8'd7) begin
         offs = prm_acc - PARAM_BG_LO;
         bg_code_pend = offs[2:0];
      end
      prm_acc = 8'd0;
   endfunction

   // Advances the shadow parser by one byte and queues any screen beat.
   function automatic void parse_byte(input logic [7:0] c);
      result_type  beat;
      logic [3:0]  fcol;
      logic [3:0]  bcol;
      int unsigned nxt;
      case (prs_state)
         ST_ESCAPE: begin
            if (c == BYTE_LBRACK) begin
               prs_state    = ST_PARAM;
               prm_acc      = 8'd0;
               first_done   = 1'b0;
               first_zero   = 1'b0;
               bright_on    = 1'b0;
               fg_code_pend = DEF_FG_CODE;
               bg_code_pend = DEF_BG_CODE;
            end else begin
               prs_state = ST_GROUND;
            end
         end
         ST_PARAM: begin
            if (c >= BYTE_ZERO && c <= BYTE_ZERO + 8'd9) begin
               nxt = int'(prm_acc) * 10 + int'(c - BYTE_ZERO);
               prm_acc = (nxt > 255) ? ACC_MAX : nxt[7:0];
            end else begin
               fold_parameter();
               if (c != BYTE_SEMI) begin
                  prs_state = ST_GROUND;
                  if (c == BYTE_M) begin
                     if (first_zero) begin
                        fg_now = DEF_FG;
                        bg_now = DEF_BG;
                     end else begin
                        fcol = display_colour(fg_code_pend);
                        bcol = display_colour(bg_code_pend);
                        if (bright_on) begin
                           fcol = fcol | BRIGHT_BIT;
                           bcol = bcol | BRIGHT_BIT;
                        end
                        fg_now = fcol;
                        bg_now = bcol;
                     end
                     beat.kind       = KIND_COLOUR;
                     beat.character  = 8'h00;
                     beat.foreground = fg_now;
                     beat.background = bg_now;
                     pending_screen.push_back(beat);
                  end
               end
            end
         end
         default: begin
            if (c == BYTE_ESC) begin
               prs_state = ST_ESCAPE;
            end else begin
               prs_state       = ST_GROUND;
               beat.kind       = KIND_CHAR;
               beat.character  = c;
               beat.foreground = fg_now;
               beat.background = bg_now;
               pending_screen.push_back(beat);
            end
         end
      endcase
   endfunction

   // Driver: offers queued bytes at the falling edge, holding each until taken.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (req_gap_left > 0) begin
            req_gap_left = req_gap_left - 1;
            req_tvalid <= 1'b0;
         end else if (byte_queue.size() > 0) begin
            req_tdata  <= byte_queue.pop_front();
            req_tvalid <= 1'b1;
            if ($urandom_range(0, 99) < req_idle_pct)
               req_gap_left = gap_len();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: random back-pressure, plus long hold-offs on request.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (long_holds_served != long_holds_asked) begin
         long_holds_served = long_holds_served + 1;
         hold_left = 300;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < rsp_idle_pct) begin
         hold_left = gap_len() - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Monitor: predicts on every accepted input beat, checks every result beat.
   always @(posedge clock) begin
      result_type want;
      req_taken = 1'b0;
      if (!reset) begin
         req_taken = req_tvalid && req_tready;
         if (req_taken) begin
            parse_byte(req_tdata);
            bytes_accepted = bytes_accepted + 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_screen.size() == 0) begin
               fault_count = fault_count + 1;
               if (fault_count <= 10)
                  $display("unexpected beat: kind %0d char %02h fg %0h bg %0h",
                           rsp_tuser, rsp_tdata[7:0], rsp_tdata[11:8], rsp_tdata[15:12]);
            end else begin
               want = pending_screen.pop_front();
               if (rsp_tuser !== want.kind || rsp_tdata[7:0] !== want.character ||
                   rsp_tdata[11:8] !== want.foreground ||
                   rsp_tdata[15:12] !== want.background) begin
                  fault_count = fault_count + 1;
                  if (fault_count <= 10) begin
                     $display("mismatch: expected kind %0d char %02h fg %0h bg %0h",
                              want.kind, want.character, want.foreground,
                              want.background);
                     $display("          actual   kind %0d char %02h fg %0h bg %0h",
                              rsp_tuser, rsp_tdata[7:0], rsp_tdata[11:8],
                              rsp_tdata[15:12]);
                  end
               end
            end
         end
      end
   end

   task automatic push_byte(input logic [7:0] b);
      byte_queue.push_back(b);
      bytes_queued = bytes_queued + 1;
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++)
         push_byte(s[i]);
   endtask

   // One control sequence with random parameters; a bad final drops it.
   task automatic push_sequence(input bit sgr_final);
      int unsigned n_par;
      logic [7:0]  fin;
      n_par = $urandom_range(1, 4);
      push_byte(BYTE_ESC);
      push_byte(BYTE_LBRACK);
      for (int i = 0; i < n_par; i++) begin
         if (i > 0)
            push_byte(BYTE_SEMI);
         case ($urandom_range(0, 7))
            0: ;
            1: push_text("0");
            2: push_text("1");
            3, 4: push_text($sformatf("%0d", 30 + $urandom_range(0, 7)));
            5: push_text($sformatf("%0d", 40 + $urandom_range(0, 7)));
            6: push_text($sformatf("%0d", $urandom_range(0, 300)));
            default: push_text($sformatf("00%0d", $urandom_range(0, 9999)));
         endcase
      end
      if (sgr_final) begin
         push_byte(BYTE_M);
      end else begin
         do
            fin = 8'($urandom_range(0, 255));
         while ((fin >= BYTE_ZERO && fin <= BYTE_ZERO + 8'd9) || fin == BYTE_SEMI ||
                fin == BYTE_M);
         push_byte(fin);
      end
   endtask

   // Mixed terminal traffic, mostly well-formed colour sequences.
   task automatic push_traffic(input int unsigned count);
      int unsigned start;
      int unsigned pick;
      logic [7:0]  b;
      start = bytes_queued;
      while (bytes_queued - start < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            repeat ($urandom_range(1, 6)) begin
               do
                  b = 8'($urandom_range(0, 255));
               while (b == BYTE_ESC);
               push_byte(b);
            end
         end else if (pick < 75) begin
            push_sequence(1'b1);
         end else if (pick < 85) begin
            push_sequence(1'b0);
         end else if (pick < 92) begin
            push_byte(BYTE_ESC);
            push_byte(8'($urandom_range(0, 255)));
         end else begin
            repeat ($urandom_range(1, 4))
               push_byte(8'($urandom_range(0, 255)));
         end
      end
   endtask

   // Waits on the falling edge until every byte is taken and every beat seen.
   task automatic wait_quiet();
      while (bytes_accepted != bytes_queued || pending_screen.size() != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // Writes all four colour registers on consecutive cycles.
   task automatic load_colours(input colour_map_type m);
      csr_wen   <= 1'b1;
      csr_addr  <= CSR_RED;
      csr_wdata <= m.red;
      @(negedge clock);
      csr_addr  <= CSR_YELLOW;
      csr_wdata <= m.yellow;
      @(negedge clock);
      csr_addr  <= CSR_BLUE;
      csr_wdata <= m.blue;
      @(negedge clock);
      csr_addr  <= CSR_CYAN;
      csr_wdata <= m.cyan;
      @(negedge clock);
      csr_wen   <= 1'b0;
      colour_map = m;
   endtask

   // Sequencer: reset, directed bytes, then random phases under new tables.
   initial begin
      colour_map_type m;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Byte extremes, a dropped escape, a full colour sequence, saturation,
      // an empty first parameter that resets, and ESC ending a sequence.
      req_idle_pct = 20;
      rsp_idle_pct = 20;
      push_byte(8'h00);
      push_byte(8'hFF);
      push_byte(BYTE_ESC);
      push_text("x");
      push_byte(BYTE_ESC);
      push_text("[1;31;44m");
      push_byte(BYTE_ESC);
      push_text("[999m");
      push_byte(BYTE_ESC);
      push_text("[;32m");
      push_byte(BYTE_ESC);
      push_text("[3");
      push_byte(BYTE_ESC);
      wait_quiet();

      for (int p = 0; p < 6; p++) begin
         case (p)
            0: m = '{red: 4'h0, yellow: 4'h0, blue: 4'h0, cyan: 4'h0};
            1: m = '{red: 4'hF, yellow: 4'hF, blue: 4'hF, cyan: 4'hF};
            default: m = 16'($urandom_range(0, 16'hFFFF));
         endcase
         load_colours(m);
         case (p)
            0: begin req_idle_pct = 20; rsp_idle_pct = 20; end
            1: begin req_idle_pct = 0;  rsp_idle_pct = 0;  end
            2: begin
               req_idle_pct = 0;
               rsp_idle_pct = 10;
               long_holds_asked = long_holds_asked + 1;
            end
            3: begin req_idle_pct = 50; rsp_idle_pct = 50; end
            4: begin req_idle_pct = 10; rsp_idle_pct = 40; end
            default: begin req_idle_pct = 30; rsp_idle_pct = 5; end
         endcase
         push_traffic(280);
         wait_quiet();
      end

      repeat (10) @(negedge clock);
      if (fault_count == 0 && pending_screen.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #20000000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== ansi_sgr_escape_parser_top.f =====
hdl/asgr_pkg.sv
hdl/asgr_csr.sv
hdl/asgr_parser.sv
hdl/asgr_out_reg.sv
hdl/ansi_sgr_escape_parser_top.sv
bench/tb_top.sv
